// File: src/hlrp_pkg.sv
// shared types, character codes and helpers for the hex load record parser
package hlrp_pkg;

  // character codes
  localparam logic [7:0] SEMICOLON_CODE = 8'h3B;
  localparam logic [7:0] NEWLINE_CODE   = 8'h0A;

  // record layout
  localparam logic [8:0] HEADER_BYTES   = 9'd3;
  localparam logic [8:0] OVERHEAD_BYTES = 9'd5;
  localparam logic [8:0] INDEX_MAX      = 9'd511;

  // field widths
  localparam int ADDR_W = 17;

  // status codes carried on a status item
  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_TRANSFER = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_LEN_ERR  = 3'd3,
    ST_CHK_ERR  = 3'd4,
    ST_EOF      = 3'd5
  } hlrp_status_t;

  // item kinds on the result channel
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // input function codes
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_EOF  = 1'b1;

  // one result item plus its valid flag
  typedef struct packed {
    logic              valid;
    logic              item_kind;
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] load_address;
    logic [7:0]        byte_count;
    hlrp_status_t      status_code;
  } hlrp_result_t;

  // hex digit decode: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// File: src/hlrp_line_state.sv
// per-line parse state and the combinational step that yields at most one result
module hlrp_line_state (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic                      func,
  input  logic [7:0]                char_code,
  output hlrp_pkg::hlrp_result_t    res
);

  logic       in_record_r, in_record_nxt;
  logic       pending_r, pending_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;
  logic [8:0] byte_index_r, byte_index_nxt;
  logic [7:0] count_byte_r, count_byte_nxt;
  logic [15:0] start_addr_r, start_addr_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0] last0_r, last0_nxt;
  logic [7:0] last1_r, last1_nxt;
  logic       any_digit_r, any_digit_nxt;

  logic [4:0]  hex;
  logic [7:0]  new_byte;
  logic [8:0]  need_bytes;
  logic [8:0]  data_end;
  logic [8:0]  offset;
  logic [15:0] chk;
  logic [15:0] given;

  // step logic: next state and the result of this transaction
  always_comb begin
    in_record_nxt   = in_record_r;
    pending_nxt     = pending_r;
    high_nibble_nxt = high_nibble_r;
    byte_index_nxt  = byte_index_r;
    count_byte_nxt  = count_byte_r;
    start_addr_nxt  = start_addr_r;
    sum_nxt         = sum_r;
    last0_nxt       = last0_r;
    last1_nxt       = last1_r;
    any_digit_nxt   = any_digit_r;

    res              = '0;
    res.status_code  = hlrp_pkg::ST_DATA;

    hex        = hlrp_pkg::hex_value(char_code);
    new_byte   = {high_nibble_r, hex[3:0]};
    need_bytes = {1'b0, count_byte_r} + hlrp_pkg::OVERHEAD_BYTES;
    data_end   = {1'b0, count_byte_r} + hlrp_pkg::HEADER_BYTES;
    offset     = byte_index_r - hlrp_pkg::HEADER_BYTES;
    chk        = sum_r - {8'd0, last0_r} - {8'd0, last1_r};
    given      = {last0_r, last1_r};

    if (func == hlrp_pkg::FUNC_EOF || char_code == hlrp_pkg::NEWLINE_CODE) begin
      // status item, then the line starts afresh
      res.valid     = 1'b1;
      res.item_kind = hlrp_pkg::KIND_STATUS;
      if (func == hlrp_pkg::FUNC_EOF) begin
        res.status_code = hlrp_pkg::ST_EOF;
      end else if (!any_digit_r) begin
        res.status_code = hlrp_pkg::ST_EMPTY;
      end else if (byte_index_r < need_bytes) begin
        res.status_code  = hlrp_pkg::ST_LEN_ERR;
        res.load_address = {1'b0, start_addr_r};
      end else if (chk != given && count_byte_r != 8'd0) begin
        res.status_code  = hlrp_pkg::ST_CHK_ERR;
        res.load_address = {1'b0, start_addr_r};
      end else begin
        res.status_code  = (count_byte_r != 8'd0) ? hlrp_pkg::ST_DATA
                                                  : hlrp_pkg::ST_TRANSFER;
        res.byte_count   = count_byte_r;
        res.load_address = {1'b0, start_addr_r};
      end
      in_record_nxt   = 1'b0;
      pending_nxt     = 1'b0;
      high_nibble_nxt = 4'd0;
      byte_index_nxt  = 9'd0;
      count_byte_nxt  = 8'd0;
      start_addr_nxt  = 16'd0;
      sum_nxt         = 16'd0;
      last0_nxt       = 8'd0;
      last1_nxt       = 8'd0;
      any_digit_nxt   = 1'b0;
    end else if (!in_record_r) begin
      // skip text until the record mark
      if (char_code == hlrp_pkg::SEMICOLON_CODE) begin
        in_record_nxt = 1'b1;
      end
    end else if (hex[4]) begin
      any_digit_nxt = 1'b1;
      if (!pending_r) begin
        high_nibble_nxt = hex[3:0];
        pending_nxt     = 1'b1;
      end else begin
        // a byte completes
        pending_nxt = 1'b0;
        if (byte_index_r == 9'd0) begin
          count_byte_nxt = new_byte;
        end else if (byte_index_r == 9'd1 || byte_index_r == 9'd2) begin
          start_addr_nxt = {start_addr_r[7:0], new_byte};
        end
        sum_nxt   = sum_r + {8'd0, new_byte};
        last0_nxt = last1_r;
        last1_nxt = new_byte;
        if (byte_index_r < hlrp_pkg::INDEX_MAX) begin
          byte_index_nxt = byte_index_r + 9'd1;
        end
        // data region: emit the byte with its address
        if (byte_index_r >= hlrp_pkg::HEADER_BYTES && byte_index_r < data_end) begin
          res.valid        = 1'b1;
          res.item_kind    = hlrp_pkg::KIND_DATA;
          res.data_byte    = new_byte;
          res.load_address = {1'b0, start_addr_r} + {8'd0, offset};
          res.byte_count   = count_byte_r;
        end
      end
    end
  end

  // state registers, updated on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_record_r   <= 1'b0;
      pending_r     <= 1'b0;
      high_nibble_r <= 4'd0;
      byte_index_r  <= 9'd0;
      count_byte_r  <= 8'd0;
      start_addr_r  <= 16'd0;
      sum_r         <= 16'd0;
      last0_r       <= 8'd0;
      last1_r       <= 8'd0;
      any_digit_r   <= 1'b0;
    end else if (step_en) begin
      in_record_r   <= in_record_nxt;
      pending_r     <= pending_nxt;
      high_nibble_r <= high_nibble_nxt;
      byte_index_r  <= byte_index_nxt;
      count_byte_r  <= count_byte_nxt;
      start_addr_r  <= start_addr_nxt;
      sum_r         <= sum_nxt;
      last0_r       <= last0_nxt;
      last1_r       <= last1_nxt;
      any_digit_r   <= any_digit_nxt;
    end
  end

endmodule

// File: src/hex_load_record_parser.sv
// top level: stream ports, parse step and the result register
// Takes one ASCII character (or an end-of-file marker) per transaction and
// can accept a new transaction every cycle while the output is not stalled:
// each character is handled by the combinational line-state step, and its
// result, if any, lands in the output register. A character is taken
// whenever that register is empty or is being drained in the same cycle, so
// a full stream runs at one transaction per clock. Data bytes appear as they
// complete; a status transaction (tuser high) closes each line or marks end
// of file. After a status other than data or transfer the bytes already sent
// for that record must be discarded by the consumer.
module hex_load_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tuser,   // [0] func (1 = end of file)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] data_byte, [24:8] load_address,
                                  // [32:25] byte_count, [35:33] status_code, rest zero
  output logic        out_tuser   // [0] item_kind (1 = record status)
);

  hlrp_pkg::hlrp_result_t res;
  hlrp_pkg::hlrp_result_t out_r;
  logic                   out_valid_r;
  logic                   accept;

  // input handshake: free when the result register is empty or draining
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  hlrp_line_state u_line_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (accept),
    .func      (in_tuser),
    .char_code (in_tdata),
    .res       (res)
  );

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_r <= res;
    end
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.item_kind;
  assign out_tdata  = {4'd0, out_r.status_code, out_r.byte_count,
                       out_r.load_address, out_r.data_byte};

endmodule
